>>> hw/rtl/infix_to_postfix_converter_defines.svh
// Assertion macros for the infix to postfix converter checks.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// General form: explicit clock and active-low reset.
`define ITP_ASSERT_ON(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Short form for modules with clk and rst_n in scope.
`define ITP_CHECK(lbl, prop, msg) \
    `ITP_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

>>> hw/rtl/itp_pkg.sv
// Shared codes, types and helpers for the infix to postfix converter.
`default_nettype none

package itp_pkg;

    localparam logic [2:0] ACT_OPERAND  = 3'd0;
    localparam logic [2:0] ACT_OPERATOR = 3'd1;
    localparam logic [2:0] ACT_OPEN     = 3'd2;
    localparam logic [2:0] ACT_CLOSE    = 3'd3;
    localparam logic [2:0] ACT_END      = 3'd4;

    localparam logic [2:0] OP_POWER     = 3'd4;
    localparam logic [2:0] PAREN_MARK   = 3'd7;

    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_OPEN  = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic       tok_load;
        logic       out_load;
        logic       out_from_hold;
        logic       out_last;
        logic [1:0] out_kind;
        logic [1:0] out_err;
        logic       hold_load;
        logic       pop;
        logic       push;
        logic       push_paren;
        logic       open_inc;
        logic       open_dec;
        logic       err_set;
        logic       clear;
    } itp_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       op_bad;
        logic       error_seen;
        logic       stack_empty;
        logic       stack_full;
        logic       open_zero;
        logic       top_valid;
        logic       top_paren;
        logic       top_pops;
        logic       out_free;
    } itp_status_t;

    // Stacked operator leaves before the incoming one is pushed.
    function automatic logic pops_before(input logic [2:0] top_code,
                                         input logic [2:0] new_code);
        logic [1:0] p_top;
        logic [1:0] p_new;
        p_top = top_code[2:1];
        p_new = new_code[2:1];
        return (p_top > p_new) || ((p_top == p_new) && (new_code != OP_POWER));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itp_if.sv
// Token and result channel interfaces.
`default_nettype none

interface itp_token_if #(parameter int OPERAND_WIDTH = 32) ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               action;
    logic [2:0]               op_code;
    logic [OPERAND_WIDTH-1:0] operand_value;

    modport source (output valid, output action, output op_code, output operand_value,
                    input ready);
    modport sink   (input valid, input action, input op_code, input operand_value,
                    output ready);
endinterface

interface itp_result_if #(parameter int OPERAND_WIDTH = 32) ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               out_kind;
    logic [2:0]               out_op;
    logic [OPERAND_WIDTH-1:0] out_value;
    logic [1:0]               error_code;
    logic                     last;

    modport source (output valid, output out_kind, output out_op, output out_value,
                    output error_code, output last, input ready);
    modport sink   (input valid, input out_kind, input out_op, input out_value,
                    input error_code, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/itp_datapath.sv
// Datapath: token register, operator stack memory, counters, hold and output registers.
`default_nettype none

module itp_datapath #(
    parameter int STACK_DEPTH   = 16,
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [2:0]               tok_action,
    input  wire logic [2:0]               tok_op,
    input  wire logic [OPERAND_WIDTH-1:0] tok_value,
    input  wire itp_pkg::itp_cmd_t        cmd,
    output      itp_pkg::itp_status_t     status,
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic [1:0]               out_kind,
    output      logic [2:0]               out_op,
    output      logic [OPERAND_WIDTH-1:0] out_value,
    output      logic [1:0]               error_code,
    output      logic                     last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [2:0]               action_reg;
    logic [2:0]               op_reg;
    logic [OPERAND_WIDTH-1:0] value_reg;

    logic [2:0]               stack_mem [STACK_DEPTH];
    logic [2:0]               rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;

    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            open_reg, open_next;
    logic                     err_reg, err_next;
    logic                     top_valid_reg, top_valid_next;
    logic [2:0]               hold_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_kind_reg;
    logic [2:0]               out_op_reg;
    logic [OPERAND_WIDTH-1:0] out_value_reg;
    logic [1:0]               out_err_reg;
    logic                     out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
        begin
            action_reg <= tok_action;
            op_reg     <= tok_op;
            value_reg  <= tok_value;
        end
    end

    assign rd_addr = (count_reg == '0) ? '0 : AW'(count_reg - CW'(1));
    assign wr_addr = count_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[wr_addr] <= cmd.push_paren ? itp_pkg::PAREN_MARK : op_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_comb
    begin
        priority if (cmd.clear)
            count_next = '0;
        else if (cmd.push)
            count_next = count_reg + CW'(1);
        else if (cmd.pop)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;

        priority if (cmd.clear)
            open_next = '0;
        else if (cmd.open_inc)
            open_next = open_reg + CW'(1);
        else if (cmd.open_dec)
            open_next = open_reg - CW'(1);
        else
            open_next = open_reg;

        priority if (cmd.clear)
            err_next = 1'b0;
        else if (cmd.err_set)
            err_next = 1'b1;
        else
            err_next = err_reg;

        // read data matches the top only once the count has stayed unchanged across a registered read
        top_valid_next = (count_next == count_reg);

        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            open_reg      <= '0;
            err_reg       <= 1'b0;
            top_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            open_reg      <= open_next;
            err_reg       <= err_next;
            top_valid_reg <= top_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hold_load)
        begin
            hold_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_from_hold)
            begin
                out_kind_reg  <= itp_pkg::KIND_OPERATOR;
                out_op_reg    <= hold_reg;
                out_value_reg <= '0;
                out_err_reg   <= itp_pkg::ERR_NONE;
            end
            else
            begin
                out_kind_reg  <= cmd.out_kind;
                out_op_reg    <= '0;
                out_value_reg <= (cmd.out_kind == itp_pkg::KIND_OPERAND) ? value_reg : '0;
                out_err_reg   <= cmd.out_err;
            end
            out_last_reg <= cmd.out_last;
        end
    end

    always_comb
    begin
        status.action      = action_reg;
        status.op_bad      = (op_reg > itp_pkg::OP_POWER);
        status.error_seen  = err_reg;
        status.stack_empty = (count_reg == '0);
        status.stack_full  = (count_reg == CW'(STACK_DEPTH));
        status.open_zero   = (open_reg == '0);
        status.top_valid   = top_valid_reg;
        status.top_paren   = (rd_data_reg == itp_pkg::PAREN_MARK);
        status.top_pops    = itp_pkg::pops_before(rd_data_reg, op_reg);
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_op     = out_op_reg;
    assign out_value  = out_value_reg;
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/itp_controller.sv
// Controller: token sequencing, pop decisions and result ordering.
`default_nettype none

module itp_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire itp_pkg::itp_status_t status,
    output      itp_pkg::itp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   hold_valid_reg, hold_valid_next;

    logic       dec_pop;
    logic       dec_direct;
    logic       dec_none;
    logic [1:0] d_kind;
    logic [1:0] d_err;
    logic       d_err_set;
    logic       d_clear;
    logic       n_push;
    logic       n_push_paren;
    logic       n_open_inc;
    logic       n_paren_pop;

    // what the held token asks for this cycle; nothing set means wait
    always_comb
    begin
        dec_pop      = 1'b0;
        dec_direct   = 1'b0;
        dec_none     = 1'b0;
        d_kind       = itp_pkg::KIND_END;
        d_err        = itp_pkg::ERR_NONE;
        d_err_set    = 1'b0;
        d_clear      = 1'b0;
        n_push       = 1'b0;
        n_push_paren = 1'b0;
        n_open_inc   = 1'b0;
        n_paren_pop  = 1'b0;

        priority if (status.action > itp_pkg::ACT_END
                     || (status.action != itp_pkg::ACT_END && status.error_seen)
                     || (status.action == itp_pkg::ACT_OPERATOR && status.op_bad))
        begin
            dec_none = 1'b1;
        end
        else
        begin
            case (status.action)
                itp_pkg::ACT_OPERAND:
                begin
                    dec_direct = 1'b1;
                    d_kind     = itp_pkg::KIND_OPERAND;
                end
                itp_pkg::ACT_OPERATOR:
                begin
                    priority if (!status.stack_empty && !status.top_valid)
                        dec_pop = 1'b0;
                    else if (!status.stack_empty && !status.top_paren && status.top_pops)
                        dec_pop = 1'b1;
                    else if (status.stack_full)
                    begin
                        dec_direct = 1'b1;
                        d_kind     = itp_pkg::KIND_ERROR;
                        d_err      = itp_pkg::ERR_OVERFLOW;
                        d_err_set  = 1'b1;
                    end
                    else
                    begin
                        dec_none = 1'b1;
                        n_push   = 1'b1;
                    end
                end
                itp_pkg::ACT_OPEN:
                begin
                    if (status.stack_full)
                    begin
                        dec_direct = 1'b1;
                        d_kind     = itp_pkg::KIND_ERROR;
                        d_err      = itp_pkg::ERR_OVERFLOW;
                        d_err_set  = 1'b1;
                    end
                    else
                    begin
                        dec_none     = 1'b1;
                        n_push       = 1'b1;
                        n_push_paren = 1'b1;
                        n_open_inc   = 1'b1;
                    end
                end
                itp_pkg::ACT_CLOSE:
                begin
                    priority if (status.open_zero)
                    begin
                        dec_direct = 1'b1;
                        d_kind     = itp_pkg::KIND_ERROR;
                        d_err      = itp_pkg::ERR_NO_OPEN;
                        d_err_set  = 1'b1;
                    end
                    else if (!status.top_valid)
                        dec_pop = 1'b0;
                    else if (!status.top_paren)
                        dec_pop = 1'b1;
                    else
                    begin
                        dec_none    = 1'b1;
                        n_paren_pop = 1'b1;
                    end
                end
                itp_pkg::ACT_END:
                begin
                    priority if (status.error_seen)
                    begin
                        dec_direct = 1'b1;
                        d_clear    = 1'b1;
                    end
                    else if (!status.open_zero)
                    begin
                        dec_direct = 1'b1;
                        d_kind     = itp_pkg::KIND_ERROR;
                        d_err      = itp_pkg::ERR_UNCLOSED;
                        d_clear    = 1'b1;
                    end
                    else if (!status.stack_empty)
                        dec_pop = status.top_valid;
                    else
                    begin
                        dec_direct = 1'b1;
                        d_clear    = 1'b1;
                    end
                end
                default:
                begin
                    dec_none = 1'b1;
                end
            endcase
        end
    end

    // a popped operator waits in the hold register until it is known
    // whether it is the token's final result
    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        in_ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.tok_load = 1'b1;
                    state_next   = S_WORK;
                end
            end
            S_WORK:
            begin
                priority if (dec_pop)
                begin
                    if (!hold_valid_reg || status.out_free)
                    begin
                        cmd.out_load      = hold_valid_reg;
                        cmd.out_from_hold = 1'b1;
                        cmd.hold_load     = 1'b1;
                        cmd.pop           = 1'b1;
                        hold_valid_next   = 1'b1;
                    end
                end
                else if (dec_direct)
                begin
                    if (status.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        if (hold_valid_reg)
                        begin
                            cmd.out_from_hold = 1'b1;
                            hold_valid_next   = 1'b0;
                        end
                        else
                        begin
                            cmd.out_kind = d_kind;
                            cmd.out_err  = d_err;
                            cmd.out_last = 1'b1;
                            cmd.err_set  = d_err_set;
                            cmd.clear    = d_clear;
                            state_next   = S_IDLE;
                        end
                    end
                end
                else if (dec_none)
                begin
                    if (!hold_valid_reg || status.out_free)
                    begin
                        cmd.out_load      = hold_valid_reg;
                        cmd.out_from_hold = 1'b1;
                        cmd.out_last      = 1'b1;
                        cmd.push          = n_push;
                        cmd.push_paren    = n_push_paren;
                        cmd.open_inc      = n_open_inc;
                        cmd.pop           = n_paren_pop;
                        cmd.open_dec      = n_paren_pop;
                        hold_valid_next   = 1'b0;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_WORK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter (shunting-yard, bounded operator stack).
//
//   channel   role   beat
//   tokens    sink   action, op_code, operand_value
//   results   source out_kind, out_op, out_value, error_code, last
//
// A token is accepted in the idle state and handled in the work state.
// Each popped operator waits for the stack memory's registered read before the
// next top can be compared; a pop that empties the stack needs no such wait.
// An end mark or overflow after pops first passes on the last popped operator,
// then gives its own beat.
// Reset clears counters, flags and the output valid; stack contents need none.
// A stalled results beat holds the work cycle; the next token is still taken
// while the final beat of the previous one waits.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH   = 16,
    parameter int OPERAND_WIDTH = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    itp_token_if.sink    tokens,
    itp_result_if.source results
);

    itp_pkg::itp_cmd_t    cmd;
    itp_pkg::itp_status_t status;

    itp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tokens.valid),
        .in_ready (tokens.ready),
        .status   (status),
        .cmd      (cmd)
    );

    itp_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_action (tokens.action),
        .tok_op     (tokens.op_code),
        .tok_value  (tokens.operand_value),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_kind   (results.out_kind),
        .out_op     (results.out_op),
        .out_value  (results.out_value),
        .error_code (results.error_code),
        .last       (results.last)
    );

endmodule

`default_nettype wire

>>> hw/rtl/itp_checker.sv
// Port-level checks on the converter's result channel, bound to the top level.
`default_nettype none

`include "infix_to_postfix_converter_defines.svh"

module itp_checker #(
    parameter int OPERAND_WIDTH = 32
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [1:0]               out_kind,
    input wire logic [2:0]               out_op,
    input wire logic [OPERAND_WIDTH-1:0] out_value,
    input wire logic [1:0]               error_code,
    input wire logic                     last
);

    `ITP_CHECK(a_valid_holds, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
    `ITP_CHECK(a_beat_stable, out_valid && !out_ready |=> $stable({out_kind, out_op, out_value, error_code, last}), "stalled result beat changed")
    `ITP_CHECK(a_error_is_last, out_valid && out_kind == itp_pkg::KIND_ERROR |-> last && error_code != itp_pkg::ERR_NONE, "error beat not final or without code")
    `ITP_CHECK(a_end_is_last, out_valid && out_kind == itp_pkg::KIND_END |-> last && error_code == itp_pkg::ERR_NONE && out_value == '0, "end beat malformed")
    `ITP_CHECK(a_operand_clean, out_valid && out_kind == itp_pkg::KIND_OPERAND |-> last && out_op == '0 && error_code == itp_pkg::ERR_NONE, "operand beat malformed")

endmodule

bind infix_to_postfix_converter itp_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_itp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_kind   (results.out_kind),
    .out_op     (results.out_op),
    .out_value  (results.out_value),
    .error_code (results.error_code),
    .last       (results.last)
);

`default_nettype wire
